>>> hw/rtl/bmp_pkg.sv
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared constants, control word layout and microprogram for the binomial
// coefficient (mod prime) core.
// ----------------------------------------------------------------------------
package bmp_pkg;

   // Field widths of the request and response
   localparam int TOP_W   = 16;
   localparam int PICK_W  = 16;
   localparam int VALUE_W = 30;

   // Factorial table
   localparam int TABLE_SIZE = 4096;
   localparam int TBL_AW     = $clog2(TABLE_SIZE);

   // Prime modulus and the derived Barrett constants
   localparam int MODULUS = 1000000007;
   localparam int MOD_W   = $clog2(MODULUS);
   localparam int MU_W    = MOD_W + 1;
   localparam int RES_W   = MOD_W + 2;
   localparam logic [MU_W-1:0]  BARRETT_MU =
      MU_W'((64'd1 << (2 * MOD_W)) / 64'(MODULUS));
   localparam logic [MOD_W-1:0] MOD_P      = MOD_W'(MODULUS);
   localparam logic [RES_W-1:0] MOD_P_X1   = RES_W'(64'(MODULUS));
   localparam logic [RES_W-1:0] MOD_P_X2   = RES_W'(64'(MODULUS) * 64'd2);

   // Fermat exponent p-2, walked from bit 0 upward
   localparam logic [MOD_W-1:0] FERMAT_EXP = MOD_W'(MODULUS - 2);
   localparam int BIT_W = $clog2(MOD_W);

   // Microprogram step addresses
   localparam int PC_W = 5;
   localparam logic [PC_W-1:0] S_INIT0     = 5'd0;
   localparam logic [PC_W-1:0] S_INIT_WR   = 5'd1;
   localparam logic [PC_W-1:0] S_INIT_MUL  = 5'd2;
   localparam logic [PC_W-1:0] S_INIT_WAIT = 5'd3;
   localparam logic [PC_W-1:0] S_INIT_JMP  = 5'd4;
   localparam logic [PC_W-1:0] S_IDLE      = 5'd5;
   localparam logic [PC_W-1:0] S_CHK       = 5'd6;
   localparam logic [PC_W-1:0] S_CHK2      = 5'd7;
   localparam logic [PC_W-1:0] S_LDB       = 5'd8;
   localparam logic [PC_W-1:0] S_LDN       = 5'd9;
   localparam logic [PC_W-1:0] S_W0        = 5'd10;
   localparam logic [PC_W-1:0] S_EA        = 5'd11;
   localparam logic [PC_W-1:0] S_EB        = 5'd12;
   localparam logic [PC_W-1:0] S_EW        = 5'd13;
   localparam logic [PC_W-1:0] S_EN        = 5'd14;
   localparam logic [PC_W-1:0] S_FIN       = 5'd15;
   localparam logic [PC_W-1:0] S_FW        = 5'd16;
   localparam logic [PC_W-1:0] S_OUT       = 5'd17;
   localparam logic [PC_W-1:0] S_OOR       = 5'd18;
   localparam logic [PC_W-1:0] S_ZERO      = 5'd19;

   // Jump conditions
   localparam logic [2:0] COND_NONE      = 3'd0;
   localparam logic [2:0] COND_ALWAYS    = 3'd1;
   localparam logic [2:0] COND_NO_START  = 3'd2;
   localparam logic [2:0] COND_MUL_BUSY  = 3'd3;
   localparam logic [2:0] COND_CNT_LAST  = 3'd4;
   localparam logic [2:0] COND_TOP_OOR   = 3'd5;
   localparam logic [2:0] COND_PICK_GT   = 3'd6;
   localparam logic [2:0] COND_BIT_MORE  = 3'd7;

   // Register actions
   localparam logic [3:0] ACT_NONE      = 4'd0;
   localparam logic [3:0] ACT_INIT      = 4'd1;
   localparam logic [3:0] ACT_CNT_INC   = 4'd2;
   localparam logic [3:0] ACT_CAPTURE   = 4'd3;
   localparam logic [3:0] ACT_LOAD_BASE = 4'd4;
   localparam logic [3:0] ACT_LOAD_NUM  = 4'd5;
   localparam logic [3:0] ACT_BIT_INC   = 4'd6;
   localparam logic [3:0] ACT_EMIT_VAL  = 4'd7;
   localparam logic [3:0] ACT_EMIT_OOR  = 4'd8;
   localparam logic [3:0] ACT_EMIT_ZERO = 4'd9;

   // Multiplier operand sources
   localparam logic [2:0] SRC_ACC   = 3'd0;
   localparam logic [2:0] SRC_BASE  = 3'd1;
   localparam logic [2:0] SRC_NUM   = 3'd2;
   localparam logic [2:0] SRC_CNT   = 3'd3;
   localparam logic [2:0] SRC_RDATA = 3'd4;

   // Multiplier result destinations
   localparam logic [1:0] DST_ACC  = 2'd0;
   localparam logic [1:0] DST_BASE = 2'd1;

   // Table address sources
   localparam logic [1:0] ADDR_CNT  = 2'd0;
   localparam logic [1:0] ADDR_PICK = 2'd1;
   localparam logic [1:0] ADDR_DIFF = 2'd2;
   localparam logic [1:0] ADDR_TOP  = 2'd3;

   typedef struct packed {
      logic [2:0]      cond;
      logic [PC_W-1:0] target;
      logic [3:0]      act;
      logic            mul_go;
      logic            mul_on_bit;
      logic [2:0]      src_a;
      logic [2:0]      src_b;
      logic [1:0]      dest;
      logic [1:0]      addr;
      logic            mem_we;
   } ctrl_word_type;

   typedef struct packed {
      logic mul_busy;
      logic cnt_last;
      logic top_oor;
      logic pick_gt;
      logic bit_more;
   } status_type;

   // Control store
   function automatic ctrl_word_type ucode(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = '0;
      case (pc)
         S_INIT0: begin
            w.act = ACT_INIT;
         end
         S_INIT_WR: begin
            w.addr   = ADDR_CNT;
            w.mem_we = 1'b1;
            w.act    = ACT_CNT_INC;
            w.cond   = COND_CNT_LAST;
            w.target = S_IDLE;
         end
         S_INIT_MUL: begin
            w.mul_go = 1'b1;
            w.src_a  = SRC_ACC;
            w.src_b  = SRC_CNT;
            w.dest   = DST_ACC;
         end
         S_INIT_WAIT: begin
            w.cond   = COND_MUL_BUSY;
            w.target = S_INIT_WAIT;
         end
         S_INIT_JMP: begin
            w.cond   = COND_ALWAYS;
            w.target = S_INIT_WR;
         end
         S_IDLE: begin
            w.act    = ACT_CAPTURE;
            w.cond   = COND_NO_START;
            w.target = S_IDLE;
         end
         S_CHK: begin
            w.addr   = ADDR_PICK;
            w.cond   = COND_TOP_OOR;
            w.target = S_OOR;
         end
         S_CHK2: begin
            w.addr   = ADDR_DIFF;
            w.act    = ACT_LOAD_BASE;
            w.cond   = COND_PICK_GT;
            w.target = S_ZERO;
         end
         S_LDB: begin
            w.addr   = ADDR_TOP;
            w.mul_go = 1'b1;
            w.src_a  = SRC_BASE;
            w.src_b  = SRC_RDATA;
            w.dest   = DST_BASE;
         end
         S_LDN: begin
            w.act = ACT_LOAD_NUM;
         end
         S_W0: begin
            w.cond   = COND_MUL_BUSY;
            w.target = S_W0;
         end
         S_EA: begin
            w.mul_go     = 1'b1;
            w.mul_on_bit = 1'b1;
            w.src_a      = SRC_ACC;
            w.src_b      = SRC_BASE;
            w.dest       = DST_ACC;
         end
         S_EB: begin
            w.mul_go = 1'b1;
            w.src_a  = SRC_BASE;
            w.src_b  = SRC_BASE;
            w.dest   = DST_BASE;
         end
         S_EW: begin
            w.cond   = COND_MUL_BUSY;
            w.target = S_EW;
         end
         S_EN: begin
            w.act    = ACT_BIT_INC;
            w.cond   = COND_BIT_MORE;
            w.target = S_EA;
         end
         S_FIN: begin
            w.mul_go = 1'b1;
            w.src_a  = SRC_ACC;
            w.src_b  = SRC_NUM;
            w.dest   = DST_ACC;
         end
         S_FW: begin
            w.cond   = COND_MUL_BUSY;
            w.target = S_FW;
         end
         S_OUT: begin
            w.act    = ACT_EMIT_VAL;
            w.cond   = COND_ALWAYS;
            w.target = S_IDLE;
         end
         S_OOR: begin
            w.act    = ACT_EMIT_OOR;
            w.cond   = COND_ALWAYS;
            w.target = S_IDLE;
         end
         S_ZERO: begin
            w.act    = ACT_EMIT_ZERO;
            w.cond   = COND_ALWAYS;
            w.target = S_IDLE;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

>>> hw/rtl/binomial_mod_prime_core.sv
// ----------------------------------------------------------------------------
// binomial_mod_prime_core
// C(n, r) mod 1e9+7 with a factorial table and Fermat inverses.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_top (n) and req_pick (r) and raise start; the query transfers
//   at a clock edge with start high and busy low. One response follows per
//   query: rsp_valid is high for exactly one cycle with rsp_value and
//   rsp_out_of_range. The receiver cannot stall; it must take the strobe.
//   After reset the core builds the factorial table (one entry per pass of
//   its write, multiply and wait steps, 4096 entries) and holds busy high.
//   For a normal query the exponent loop runs 30 bits on the one shared
//   3-stage modular multiplier, with r! * (n-r)! inverted once. Queries
//   with n beyond the table, and queries with r > n, answer straight from
//   the range checks without using the multiplier.
//   busy drops in the cycle the strobe shows, so the next query may
//   transfer in that same cycle.
// ----------------------------------------------------------------------------
module binomial_mod_prime_core
   import bmp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [TOP_W-1:0]   req_top,
   input  logic [PICK_W-1:0]  req_pick,
   output logic               rsp_valid,
   output logic [VALUE_W-1:0] rsp_value,
   output logic               rsp_out_of_range
);

   ctrl_word_type ctrl;
   status_type    status;

   bmp_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   bmp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .req_top          (req_top),
      .req_pick         (req_pick),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_value        (rsp_value),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

>>> hw/rtl/bmp_modmul.sv
// ----------------------------------------------------------------------------
// bmp_modmul
// Pipelined modular multiplier, Barrett reduction over three register stages.
// Each issue carries a destination tag that comes back with the result.
// ----------------------------------------------------------------------------
module bmp_modmul
   import bmp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [1:0]       dest,
   input  logic [MOD_W-1:0] op_a,
   input  logic [MOD_W-1:0] op_b,
   output logic             busy,
   output logic             wb_valid,
   output logic [1:0]       wb_dest,
   output logic [MOD_W-1:0] wb_value
);

   logic                 v1_ff, v2_ff, v3_ff;
   logic [1:0]           d1_ff, d2_ff, d3_ff;
   logic [2*MOD_W-1:0]   prod_in, prod_ff;
   logic [MU_W-1:0]      q1;
   logic [2*MU_W-1:0]    q2;
   logic [MU_W-1:0]      q3_ff;
   logic [RES_W-1:0]     xlo2_ff, xlo3_ff;
   logic [MU_W+MOD_W-1:0] tprod;
   logic [RES_W-1:0]     t_ff;
   logic [RES_W-1:0]     resid, sub1, sub2, red;

   assign prod_in = op_a * op_b;
   assign q1      = prod_ff[2*MOD_W-1:MOD_W-1];
   assign q2      = q1 * BARRETT_MU;
   assign tprod   = q3_ff * MOD_P;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= go;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      d1_ff   <= dest;
      q3_ff   <= q2[2*MU_W-1:MU_W];
      xlo2_ff <= prod_ff[RES_W-1:0];
      d2_ff   <= d1_ff;
      t_ff    <= tprod[RES_W-1:0];
      xlo3_ff <= xlo2_ff;
      d3_ff   <= d2_ff;
   end

   // Barrett remainder is below 3p: fold with one of two subtractions
   always_comb begin
      resid = xlo3_ff - t_ff;
      sub1  = resid - MOD_P_X1;
      sub2  = resid - MOD_P_X2;
      if (resid >= MOD_P_X2) begin
         red = sub2;
      end else if (resid >= MOD_P_X1) begin
         red = sub1;
      end else begin
         red = resid;
      end
   end

   assign busy     = v1_ff | v2_ff | v3_ff;
   assign wb_valid = v3_ff;
   assign wb_dest  = d3_ff;
   assign wb_value = red[MOD_W-1:0];

endmodule

>>> hw/rtl/bmp_datapath.sv
// ----------------------------------------------------------------------------
// bmp_datapath
// Working registers, factorial table memory, shared modular multiplier and
// the response register, all steered by the current control word.
// ----------------------------------------------------------------------------
module bmp_datapath
   import bmp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ctrl_word_type      ctrl,
   input  logic [TOP_W-1:0]   req_top,
   input  logic [PICK_W-1:0]  req_pick,
   output status_type         status,
   output logic               rsp_valid,
   output logic [VALUE_W-1:0] rsp_value,
   output logic               rsp_out_of_range
);

   logic [MOD_W-1:0]  fact_mem [TABLE_SIZE];
   logic [MOD_W-1:0]  rdata_ff;
   logic [TBL_AW-1:0] mem_addr;

   logic [TOP_W-1:0]  top_ff, top_in;
   logic [PICK_W-1:0] pick_ff, pick_in;
   logic [MOD_W-1:0]  acc_ff, acc_in;
   logic [MOD_W-1:0]  base_ff, base_in;
   logic [MOD_W-1:0]  num_ff, num_in;
   logic [TBL_AW-1:0] cnt_ff, cnt_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_oor_ff, rsp_oor_in;

   logic             mul_go;
   logic [MOD_W-1:0] op_a, op_b;
   logic             mul_busy;
   logic             wb_valid;
   logic [1:0]       wb_dest;
   logic [MOD_W-1:0] wb_value;

   function automatic logic [MOD_W-1:0] pick_src(input logic [2:0] src,
                                                 input logic [MOD_W-1:0] acc,
                                                 input logic [MOD_W-1:0] base,
                                                 input logic [MOD_W-1:0] num,
                                                 input logic [TBL_AW-1:0] cnt,
                                                 input logic [MOD_W-1:0] rd);
      logic [MOD_W-1:0] v;
      case (src)
         SRC_ACC:   v = acc;
         SRC_BASE:  v = base;
         SRC_NUM:   v = num;
         SRC_CNT:   v = MOD_W'(cnt);
         SRC_RDATA: v = rd;
         default:   v = '0;
      endcase
      return v;
   endfunction

   // Square-and-multiply: skip the accumulate step on a clear exponent bit
   assign mul_go = ctrl.mul_go & (~ctrl.mul_on_bit | FERMAT_EXP[bit_ff]);
   assign op_a   = pick_src(ctrl.src_a, acc_ff, base_ff, num_ff, cnt_ff, rdata_ff);
   assign op_b   = pick_src(ctrl.src_b, acc_ff, base_ff, num_ff, cnt_ff, rdata_ff);

   bmp_modmul u_modmul (
      .clock    (clock),
      .reset    (reset),
      .go       (mul_go),
      .dest     (ctrl.dest),
      .op_a     (op_a),
      .op_b     (op_b),
      .busy     (mul_busy),
      .wb_valid (wb_valid),
      .wb_dest  (wb_dest),
      .wb_value (wb_value)
   );

   always_comb begin
      case (ctrl.addr)
         ADDR_CNT:  mem_addr = cnt_ff;
         ADDR_PICK: mem_addr = TBL_AW'(pick_ff);
         ADDR_DIFF: mem_addr = TBL_AW'(top_ff - pick_ff);
         ADDR_TOP:  mem_addr = TBL_AW'(top_ff);
         default:   mem_addr = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.mem_we) begin
         fact_mem[mem_addr] <= acc_ff;
      end
      rdata_ff <= fact_mem[mem_addr];
   end

   always_comb begin
      top_in       = top_ff;
      pick_in      = pick_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      num_in       = num_ff;
      cnt_in       = cnt_ff;
      bit_in       = bit_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_oor_in   = rsp_oor_ff;
      case (ctrl.act)
         ACT_NONE: begin
         end
         ACT_INIT: begin
            acc_in = MOD_W'(1);
            cnt_in = '0;
         end
         ACT_CNT_INC: begin
            cnt_in = cnt_ff + 1'b1;
         end
         ACT_CAPTURE: begin
            top_in  = req_top;
            pick_in = req_pick;
         end
         ACT_LOAD_BASE: begin
            base_in = rdata_ff;
         end
         ACT_LOAD_NUM: begin
            num_in = rdata_ff;
            acc_in = MOD_W'(1);
            bit_in = '0;
         end
         ACT_BIT_INC: begin
            bit_in = bit_ff + 1'b1;
         end
         ACT_EMIT_VAL: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = VALUE_W'(acc_ff);
            rsp_oor_in   = 1'b0;
         end
         ACT_EMIT_OOR: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = '0;
            rsp_oor_in   = 1'b1;
         end
         ACT_EMIT_ZERO: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = '0;
            rsp_oor_in   = 1'b0;
         end
         default: begin
         end
      endcase
      if (wb_valid) begin
         case (wb_dest)
            DST_ACC:  acc_in  = wb_value;
            DST_BASE: base_in = wb_value;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff       <= top_in;
      pick_ff      <= pick_in;
      acc_ff       <= acc_in;
      base_ff      <= base_in;
      num_ff       <= num_in;
      cnt_ff       <= cnt_in;
      bit_ff       <= bit_in;
      rsp_value_ff <= rsp_value_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   always_comb begin
      status.mul_busy = mul_busy;
      status.cnt_last = cnt_ff == TBL_AW'(TABLE_SIZE - 1);
      status.top_oor  = 32'(top_ff) >= 32'(TABLE_SIZE);
      status.pick_gt  = pick_ff > top_ff;
      status.bit_more = bit_ff != BIT_W'(MOD_W - 1);
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

>>> hw/rtl/bmp_sequencer.sv
// ----------------------------------------------------------------------------
// bmp_sequencer
// Step counter over the control store, with conditional jumps on datapath
// status and on the start command.
// ----------------------------------------------------------------------------
module bmp_sequencer
   import bmp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  status_type    status,
   output ctrl_word_type ctrl,
   output logic          busy
);

   logic [PC_W-1:0] pc_ff, pc_in;
   ctrl_word_type   word;
   logic            take;

   always_comb begin
      word = ucode(pc_ff);
      case (word.cond)
         COND_NONE:     take = 1'b0;
         COND_ALWAYS:   take = 1'b1;
         COND_NO_START: take = ~start;
         COND_MUL_BUSY: take = status.mul_busy;
         COND_CNT_LAST: take = status.cnt_last;
         COND_TOP_OOR:  take = status.top_oor;
         COND_PICK_GT:  take = status.pick_gt;
         COND_BIT_MORE: take = status.bit_more;
         default:       take = 1'b0;
      endcase
      pc_in = take ? word.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_INIT0;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl = word;
   assign busy = pc_ff != S_IDLE;

endmodule

>>> hw/rtl/bmp_checker.sv
// ----------------------------------------------------------------------------
// bmp_checker
// Port-level checks on the binomial core, bound to the top level.
// ----------------------------------------------------------------------------
module bmp_checker
   import bmp_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [TOP_W-1:0]   req_top,
   input logic               rsp_valid,
   input logic [VALUE_W-1:0] rsp_value,
   input logic               rsp_out_of_range
);

   // An accepted query keeps the core busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted query did not raise busy");

   // Response strobe lasts one cycle and shows only when the core is free
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy ##1 !rsp_valid)
      else $error("response strobe overlaps busy or repeats");

   // Reduced value stays below the modulus, and is zero when out of range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_value) < 32'(MODULUS)) &&
                    (!rsp_out_of_range || rsp_value == '0))
      else $error("response value malformed");

   // n beyond the table is answered through the check and out-of-range steps, flagged
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (32'(req_top) >= 32'(TABLE_SIZE))
      |-> ##3 rsp_valid && rsp_out_of_range)
      else $error("out-of-range query not flagged");

endmodule

bind binomial_mod_prime_core bmp_checker u_bmp_checker (.*);

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for binomial_mod_prime_core: drives (n, r) queries over
// start/busy, predicts C(n, r) mod p from its own factorial table and Fermat
// inverses, and checks every response strobe in order.
// ----------------------------------------------------------------------------
module tb;
   import bmp_pkg::*;

   localparam int NUM_RANDOM  = 1750;
   localparam int STALL_LIMIT = 150000;
   localparam int TAIL_CYCLES = 400;

   typedef struct packed {
      logic [TOP_W-1:0]  top;
      logic [PICK_W-1:0] pick;
      logic              drain;
   } query_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               out_of_range;
   } binom_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [TOP_W-1:0]   req_top = '0;
   logic [PICK_W-1:0]  req_pick = '0;
   logic               busy;
   logic               rsp_valid;
   logic [VALUE_W-1:0] rsp_value;
   logic               rsp_out_of_range;

   logic [VALUE_W-1:0] fact_mod [TABLE_SIZE];
   query_type          pending_queries[$];
   binom_type          expected_binoms[$];

   int num_queries   = 0;
   int n_issued      = 0;
   int n_sent        = 0;
   int n_checked     = 0;
   int n_errors      = 0;
   int n_full        = 0;
   int n_zero        = 0;
   int n_oor         = 0;
   int stall_cycles  = 0;

   binomial_mod_prime_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_top          (req_top),
      .req_pick         (req_pick),
      .rsp_valid        (rsp_valid),
      .rsp_value        (rsp_value),
      .rsp_out_of_range (rsp_out_of_range)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic logic [63:0] mod_mult(logic [63:0] a, logic [63:0] b);
      return (a * b) % 64'(MODULUS);
   endfunction

   // Square-and-multiply over the exponent p-2, lowest bit first
   function automatic logic [63:0] fermat_inv(logic [VALUE_W-1:0] x);
      logic [63:0] acc;
      logic [63:0] sq;
      logic [29:0] ex;
      ex  = 30'(MODULUS - 2);
      acc = 64'd1;
      sq  = 64'(x) % 64'(MODULUS);
      for (int i = 0; i < 30; i++) begin
         if (ex[i])
            acc = mod_mult(acc, sq);
         sq = mod_mult(sq, sq);
      end
      return acc;
   endfunction

   function automatic binom_type binom_expect(logic [TOP_W-1:0] n,
                                              logic [PICK_W-1:0] r);
      binom_type   res;
      logic [63:0] v;
      res = '0;
      if (int'(n) >= TABLE_SIZE) begin
         res.out_of_range = 1'b1;
      end else if (r <= n) begin
         v = 64'(fact_mod[n]);
         v = mod_mult(v, fermat_inv(fact_mod[r]));
         v = mod_mult(v, fermat_inv(fact_mod[n - r]));
         res.value = VALUE_W'(v);
      end
      return res;
   endfunction

   task automatic add_query(int n, int r, bit drain);
      query_type q;
      q.top   = TOP_W'(n);
      q.pick  = PICK_W'(r);
      q.drain = drain;
      pending_queries.push_back(q);
   endtask

   // Fill the factorial table and the stimulus, then wait for the run to settle
   initial begin
      logic [63:0] run;
      int          n;
      int          r;
      int          kind;
      run = 64'd1;
      fact_mod[0] = VALUE_W'(run);
      for (int k = 1; k < TABLE_SIZE; k++) begin
         run = mod_mult(run, 64'(k));
         fact_mod[k] = VALUE_W'(run);
      end

      add_query(0, 0, 1'b0);
      add_query(1, 0, 1'b0);
      add_query(1, 1, 1'b0);
      add_query(0, 1, 1'b0);
      add_query(2, 1, 1'b0);
      add_query(10, 3, 1'b0);
      add_query(3, 10, 1'b0);
      add_query(100, 50, 1'b0);
      add_query(TABLE_SIZE - 1, 0, 1'b0);
      add_query(TABLE_SIZE - 1, 1, 1'b0);
      add_query(TABLE_SIZE - 1, TABLE_SIZE / 2, 1'b0);
      add_query(TABLE_SIZE - 1, TABLE_SIZE - 2, 1'b0);
      add_query(TABLE_SIZE - 1, TABLE_SIZE - 1, 1'b0);
      add_query(TABLE_SIZE - 1, TABLE_SIZE, 1'b0);
      add_query(TABLE_SIZE - 1, 65535, 1'b0);
      add_query(0, 65535, 1'b0);
      add_query(TABLE_SIZE, 0, 1'b0);
      add_query(TABLE_SIZE, TABLE_SIZE, 1'b0);
      add_query(12345, 7, 1'b0);
      add_query(65535, 0, 1'b0);
      add_query(65535, 65535, 1'b0);
      add_query(21845, 43690, 1'b0);

      for (int i = 0; i < NUM_RANDOM; i++) begin
         kind = $urandom_range(99);
         if (kind < 80) begin
            n = $urandom_range(TABLE_SIZE - 1);
            r = $urandom_range(n);
         end else if (kind < 90) begin
            n = $urandom_range(TABLE_SIZE - 2);
            r = $urandom_range(65535, n + 1);
         end else begin
            n = $urandom_range(65535, TABLE_SIZE);
            r = $urandom_range(65535);
         end
         // hold off now and then until the block has answered everything
         add_query(n, r, (i % 400) == 0);
      end
      num_queries = pending_queries.size();

      @(negedge clock);
      while (pending_queries.size() != 0 || start || n_sent != n_checked)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (expected_binoms.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time,
                  expected_binoms.size());
         n_errors = n_errors + expected_binoms.size();
      end
      $display("Checked %0d responses: %0d full coefficients, %0d r above n, %0d n out of table",
               n_checked, n_full, n_zero, n_oor);
      $display("Sender idled at 21%%, 83%% and 0%% with full drains between; %0d errors",
               n_errors);
      if (n_errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Driver: present the next query, hold it until it transfers
   always @(posedge clock) begin : drive_proc
      query_type q;
      logic      take;
      logic      go;
      int        idle_pct;
      if (!reset) begin
         take = start && !busy;
         if (take) begin
            expected_binoms.push_back(binom_expect(req_top, req_pick));
            n_sent <= n_sent + 1;
         end
         if (!start || take) begin
            if (n_issued < num_queries / 3)
               idle_pct = 21;
            else if (n_issued < (2 * num_queries) / 3)
               idle_pct = 83;
            else
               idle_pct = 0;
            go = 1'b0;
            if (pending_queries.size() != 0) begin
               if (pending_queries[0].drain && (take || n_sent != n_checked))
                  go = 1'b0;
               else
                  go = ($urandom_range(99) >= idle_pct);
            end
            if (go) begin
               q = pending_queries.pop_front();
               req_top  <= q.top;
               req_pick <= q.pick;
               start    <= 1'b1;
               n_issued <= n_issued + 1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each strobed response with the oldest prediction
   always @(posedge clock) begin : check_proc
      binom_type exp_r;
      if (!reset && rsp_valid) begin
         if (expected_binoms.size() == 0) begin
            $display("%0t: response with nothing expected: value %0d oor %0b",
                     $time, rsp_value, rsp_out_of_range);
            n_errors++;
         end else begin
            exp_r = expected_binoms.pop_front();
            if (rsp_value !== exp_r.value) begin
               $display("%0t: value mismatch: expected %0d actual %0d",
                        $time, exp_r.value, rsp_value);
               n_errors++;
            end
            if (rsp_out_of_range !== exp_r.out_of_range) begin
               $display("%0t: out_of_range mismatch: expected %0b actual %0b",
                        $time, exp_r.out_of_range, rsp_out_of_range);
               n_errors++;
            end
            if (exp_r.out_of_range)
               n_oor++;
            else if (exp_r.value == '0)
               n_zero++;
            else
               n_full++;
            n_checked <= n_checked + 1;
         end
      end
   end

   // Watchdog: give up when nothing transfers for too long
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

>>> binomial_mod_prime_core.f
hw/rtl/bmp_pkg.sv
hw/rtl/bmp_modmul.sv
hw/rtl/bmp_datapath.sv
hw/rtl/bmp_sequencer.sv
hw/rtl/binomial_mod_prime_core.sv
hw/rtl/bmp_checker.sv
test/tb.sv
